@@ sv/msd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the sequence command decoder
// Event codes, table geometry and the op word that runs from the front
// end through the queue to the back end.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Note table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Command byte codes
    localparam logic [7:0] CODE_END_LOOP = 8'hFE;
    localparam logic [7:0] CODE_END_STOP = 8'hFF;
    localparam logic [9:0] REST_SPAN     = 10'd16;
    localparam logic [9:0] INST_SPAN     = 10'd32;
    localparam logic [7:0] INST_OFFSET   = 8'd15;

    // Event kinds on the result channel
    localparam logic [2:0] EV_NOTE     = 3'd0;
    localparam logic [2:0] EV_REST     = 3'd1;
    localparam logic [2:0] EV_INST     = 3'd2;
    localparam logic [2:0] EV_ROW      = 3'd3;
    localparam logic [2:0] EV_END_LOOP = 3'd4;
    localparam logic [2:0] EV_END_STOP = 3'd5;

    // Queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Operation handed from front end to back end
    typedef enum logic [1:0] {
        OP_WR_CHAN = 2'd0,
        OP_WR_VAL  = 2'd1,
        OP_NOTE    = 2'd2,
        OP_EVENT   = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t   op;
        logic [7:0] addr;   // table index for writes and note reads
        logic [7:0] data;   // table data, or event value
        logic [2:0] kind;   // event kind for direct events
        logic [4:0] chan;   // channel 0..16 for direct events
    } op_word_t;

    // Front end phase, one-hot
    typedef enum logic [4:0] {
        PH_COUNT  = 5'b00001,
        PH_CHANS  = 5'b00010,
        PH_VALUES = 5'b00100,
        PH_CMD    = 5'b01000,
        PH_INST   = 5'b10000
    } phase_t;

endpackage

@@ sv/music_sequence_command_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_sequence_command_decoder_core: song sequence command decoder
// Parses a song byte stream (note count, channel table, value table,
// commands) and emits one event per note, rest, instrument, row or end.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel: byte_valid / byte_stall / byte_value. A word is taken at a
//   rising edge with byte_valid high and byte_stall low.
//   Event channel: event_valid / event_stall / event_kind, channel, value.
//   Header bytes, table bytes and instrument command bytes give no event;
//   the instrument event comes out with the byte that follows the command.
//   Throughput: one byte per cycle while byte_stall is low. An event passes
//   through a queue slot, the table read register and the output register.
//   A four-word op queue sits between the parser and the table/output
//   stage; byte_stall rises only when that queue is full, which happens
//   when event_stall holds the output long enough.
//   Reset clears the parser to await a note count and empties the queue
//   and output stage. The note tables are not cleared; a note only reads
//   entries loaded by its own song header.
// ----------------------------------------------------------------------------
module music_sequence_command_decoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] byte_value,
    output logic       event_valid,
    input  logic       event_stall,
    output logic [2:0] event_kind,
    output logic [8:0] channel,
    output logic [7:0] value
);

    logic              q_full;
    logic              q_not_empty;
    logic              push;
    logic              pop;
    msd_pkg::op_word_t push_word;
    msd_pkg::op_word_t head_word;

    msd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_value (byte_value),
        .q_full     (q_full),
        .push       (push),
        .push_word  (push_word)
    );

    msd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head_word  (head_word)
    );

    msd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_word   (head_word),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .channel     (channel),
        .value       (value)
    );

endmodule

@@ sv/msd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_front: byte parser and command classifier
// Tracks the song phase, turns table bytes into table write ops and
// command bytes into note or direct event ops for the back end.
// ----------------------------------------------------------------------------
module msd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        byte_value,
    input  logic              q_full,
    output logic              push,
    output msd_pkg::op_word_t push_word
);

    msd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] note_count_reg, note_count_next;
    logic [7:0] load_index_reg, load_index_next;
    logic [4:0] pending_reg, pending_next;

    logic       accept;
    logic [9:0] b_w, n_w, rest_lim, inst_lim;
    logic       load_last;
    logic [7:0] b_minus_n;

    assign byte_stall = q_full;
    assign accept     = byte_valid & ~q_full;

    // Widened compare operands so large note counts do not wrap
    assign b_w       = {2'b00, byte_value};
    assign n_w       = {2'b00, note_count_reg};
    assign rest_lim  = n_w + msd_pkg::REST_SPAN;
    assign inst_lim  = n_w + msd_pkg::INST_SPAN;
    assign load_last = ({1'b0, load_index_reg} + 9'd1) >= {1'b0, note_count_reg};
    assign b_minus_n = byte_value - note_count_reg;

    // Phase handling and classification
    always_comb
    begin
        phase_next      = phase_reg;
        note_count_next = note_count_reg;
        load_index_next = load_index_reg;
        pending_next    = pending_reg;
        push            = 1'b0;
        push_word       = '0;
        push_word.op    = msd_pkg::OP_EVENT;
        case (phase_reg)
            msd_pkg::PH_CHANS:
            begin
                push           = accept;
                push_word.op   = msd_pkg::OP_WR_CHAN;
                push_word.addr = load_index_reg;
                push_word.data = byte_value;
                if (accept)
                begin
                    if (load_last)
                    begin
                        load_index_next = '0;
                        phase_next      = msd_pkg::PH_VALUES;
                    end
                    else
                        load_index_next = load_index_reg + 8'd1;
                end
            end
            msd_pkg::PH_VALUES:
            begin
                push           = accept;
                push_word.op   = msd_pkg::OP_WR_VAL;
                push_word.addr = load_index_reg;
                push_word.data = byte_value;
                if (accept)
                begin
                    if (load_last)
                    begin
                        load_index_next = '0;
                        phase_next      = msd_pkg::PH_CMD;
                    end
                    else
                        load_index_next = load_index_reg + 8'd1;
                end
            end
            msd_pkg::PH_INST:
            begin
                push           = accept;
                push_word.kind = msd_pkg::EV_INST;
                push_word.chan = pending_reg;
                push_word.data = byte_value;
                if (accept)
                    phase_next = msd_pkg::PH_CMD;
            end
            msd_pkg::PH_CMD:
            begin
                push_word.addr = byte_value;
                if (b_w < n_w)
                begin
                    push         = accept;
                    push_word.op = msd_pkg::OP_NOTE;
                end
                else if (b_w < rest_lim)
                begin
                    push           = accept;
                    push_word.kind = msd_pkg::EV_REST;
                    push_word.chan = b_minus_n[4:0] + 5'd1;
                end
                else if (b_w < inst_lim)
                begin
                    if (accept)
                    begin
                        pending_next = 5'(b_minus_n - msd_pkg::INST_OFFSET);
                        phase_next   = msd_pkg::PH_INST;
                    end
                end
                else if (byte_value < msd_pkg::CODE_END_LOOP)
                begin
                    push           = accept;
                    push_word.kind = msd_pkg::EV_ROW;
                    push_word.data = 8'(b_w - inst_lim);
                end
                else
                begin
                    push           = accept;
                    push_word.kind = (byte_value == msd_pkg::CODE_END_LOOP)
                                   ? msd_pkg::EV_END_LOOP : msd_pkg::EV_END_STOP;
                    if (accept)
                        phase_next = msd_pkg::PH_COUNT;
                end
            end
            default:
            begin
                // Header byte: note count
                if (accept)
                begin
                    note_count_next = byte_value;
                    load_index_next = '0;
                    phase_next      = (byte_value == 8'd0) ? msd_pkg::PH_CMD
                                                           : msd_pkg::PH_CHANS;
                end
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= msd_pkg::PH_COUNT;
            note_count_reg <= '0;
            load_index_reg <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            note_count_reg <= note_count_next;
            load_index_reg <= load_index_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

@@ sv/msd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_queue: small op queue between front end and back end
// Circular buffer with a fill count; head word is visible while not empty.
// ----------------------------------------------------------------------------
module msd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  msd_pkg::op_word_t push_word,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output msd_pkg::op_word_t head_word
);

    msd_pkg::op_word_t entry_reg [msd_pkg::QUEUE_DEPTH];
    logic [msd_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [msd_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (msd_pkg::QUEUE_AW + 1)'(msd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = entry_reg[rd_ptr_reg];

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

@@ sv/msd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_back: note tables and event output
// Applies table writes, reads the note tables for note ops and drives
// the registered event output.
// ----------------------------------------------------------------------------
module msd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  msd_pkg::op_word_t head_word,
    output logic              pop,
    output logic              event_valid,
    input  logic              event_stall,
    output logic [2:0]        event_kind,
    output logic [8:0]        channel,
    output logic [7:0]        value
);

    logic [7:0] chan_mem [msd_pkg::TABLE_DEPTH];
    logic [7:0] val_mem  [msd_pkg::TABLE_DEPTH];

    logic [msd_pkg::TBL_AW-1:0] idx;
    logic       in_range;
    logic       has_result;
    logic       out_ready, s1_ready;

    // Stage 1: table read data and direct event fields
    logic       s1_valid_reg;
    logic       s1_note_reg;
    logic       s1_hit_reg;
    logic [2:0] s1_kind_reg;
    logic [4:0] s1_chan_reg;
    logic [7:0] s1_data_reg;
    logic [7:0] rd_chan_reg, rd_val_reg;

    // Output register
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [8:0] out_chan_reg;
    logic [7:0] out_value_reg;

    assign idx        = head_word.addr[msd_pkg::TBL_AW-1:0];
    assign in_range   = {1'b0, head_word.addr} < 9'(msd_pkg::TABLE_DEPTH);
    assign has_result = (head_word.op == msd_pkg::OP_NOTE)
                     || (head_word.op == msd_pkg::OP_EVENT);

    // Ready chain
    assign out_ready = !out_valid_reg || !event_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = q_not_empty && s1_ready;

    // Note tables: write on table ops, registered read on note ops
    always_ff @(posedge clk)
    begin
        if (pop && in_range && head_word.op == msd_pkg::OP_WR_CHAN)
            chan_mem[idx] <= head_word.data;
        if (pop && in_range && head_word.op == msd_pkg::OP_WR_VAL)
            val_mem[idx] <= head_word.data;
        if (pop && head_word.op == msd_pkg::OP_NOTE)
        begin
            rd_chan_reg <= chan_mem[idx];
            rd_val_reg  <= val_mem[idx];
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= pop && has_result;
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_note_reg <= (head_word.op == msd_pkg::OP_NOTE);
            s1_hit_reg  <= in_range;
            s1_kind_reg <= head_word.kind;
            s1_chan_reg <= head_word.chan;
            s1_data_reg <= head_word.data;
        end
    end

    // Output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    // Output payload; out-of-range note reads use zero table data
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_ready)
        begin
            if (s1_note_reg)
            begin
                out_kind_reg  <= msd_pkg::EV_NOTE;
                out_chan_reg  <= {1'b0, (s1_hit_reg ? rd_chan_reg : 8'd0)} + 9'd1;
                out_value_reg <= s1_hit_reg ? rd_val_reg : 8'd0;
            end
            else
            begin
                out_kind_reg  <= s1_kind_reg;
                out_chan_reg  <= {4'b0000, s1_chan_reg};
                out_value_reg <= s1_data_reg;
            end
        end
    end

    assign event_valid = out_valid_reg;
    assign event_kind  = out_kind_reg;
    assign channel     = out_chan_reg;
    assign value       = out_value_reg;

endmodule

@@ sv/msd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_checker: port-level checks for the sequence command decoder
// Watches the event channel for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module msd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       event_valid,
    input logic       event_stall,
    input logic [2:0] event_kind,
    input logic [8:0] channel,
    input logic [7:0] value
);

    // A stalled event holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=> event_valid && $stable(event_kind)
                                      && $stable(channel) && $stable(value))
        else $error("event changed while stalled");

    // Rest carries channel 1..16 and no value
    a_rest_fields: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_kind == msd_pkg::EV_REST |->
            channel >= 9'd1 && channel <= 9'd16 && value == 8'd0)
        else $error("bad rest fields");

    // Instrument channel is 1..16
    a_inst_chan: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_kind == msd_pkg::EV_INST |->
            channel >= 9'd1 && channel <= 9'd16)
        else $error("bad instrument channel");

    // Row time and song end carry no channel
    a_row_end_chan: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind == msd_pkg::EV_ROW
                        || event_kind == msd_pkg::EV_END_LOOP
                        || event_kind == msd_pkg::EV_END_STOP) |-> channel == 9'd0)
        else $error("row or end with channel");

    // Notes always have a nonzero channel
    a_note_chan: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_kind == msd_pkg::EV_NOTE |-> channel != 9'd0)
        else $error("note with zero channel");

endmodule

bind music_sequence_command_decoder_core msd_checker u_msd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .channel     (channel),
    .value       (value)
);

@@ verif/music_sequence_command_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_sequence_command_decoder_core_tb: self-checking bench for the decoder
// Feeds song byte streams through the byte channel and checks every event
// against an in-bench decoder. A short table of directed words comes
// first. Random songs with random content follow, under three idle
// patterns, and the run closes with one song whose note count is large.
// ----------------------------------------------------------------------------
module music_sequence_command_decoder_core_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1150;
    localparam int FINAL_CMDS   = 48;
    localparam int SETTLE_TICKS = 16;

    // One decoded event
    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] chan;
        logic [7:0] val;
    } evt_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,   // expected event comes from the decoder model
        CHK_QUIET = 2'd1,   // no event may follow this word
        CHK_EVENT = 2'd2    // expected event typed into the row
    } row_chk_t;

    typedef struct packed {
        logic [7:0] b;
        row_chk_t   chk;
        evt_t       ev;
    } stim_row_t;

    localparam evt_t NO_EVT = '0;

    // Directed stream: zero note count, rest and instrument edges, row time
    // edges, both end codes, a two-note song with channel 256, a one-note song
    localparam stim_row_t DIR_ROWS [25] = '{
        '{8'h00, CHK_QUIET, NO_EVT},
        '{8'h00, CHK_EVENT, '{msd_pkg::EV_REST, 9'd1, 8'd0}},
        '{8'h0F, CHK_EVENT, '{msd_pkg::EV_REST, 9'd16, 8'd0}},
        '{8'h10, CHK_QUIET, NO_EVT},
        '{8'hFF, CHK_EVENT, '{msd_pkg::EV_INST, 9'd1, 8'hFF}},
        '{8'h1F, CHK_QUIET, NO_EVT},
        '{8'h00, CHK_EVENT, '{msd_pkg::EV_INST, 9'd16, 8'h00}},
        '{8'h20, CHK_EVENT, '{msd_pkg::EV_ROW, 9'd0, 8'h00}},
        '{8'hFD, CHK_EVENT, '{msd_pkg::EV_ROW, 9'd0, 8'hDD}},
        '{8'hFE, CHK_EVENT, '{msd_pkg::EV_END_LOOP, 9'd0, 8'd0}},
        '{8'h02, CHK_QUIET, NO_EVT},
        '{8'h00, CHK_QUIET, NO_EVT},
        '{8'hFF, CHK_QUIET, NO_EVT},
        '{8'h80, CHK_QUIET, NO_EVT},
        '{8'h7F, CHK_QUIET, NO_EVT},
        '{8'h01, CHK_MODEL, NO_EVT},
        '{8'h00, CHK_MODEL, NO_EVT},
        '{8'h02, CHK_EVENT, '{msd_pkg::EV_REST, 9'd1, 8'd0}},
        '{8'h22, CHK_MODEL, NO_EVT},
        '{8'hFF, CHK_EVENT, '{msd_pkg::EV_END_STOP, 9'd0, 8'd0}},
        '{8'h01, CHK_QUIET, NO_EVT},
        '{8'h5A, CHK_QUIET, NO_EVT},
        '{8'h33, CHK_QUIET, NO_EVT},
        '{8'h00, CHK_MODEL, NO_EVT},
        '{8'hFE, CHK_EVENT, '{msd_pkg::EV_END_LOOP, 9'd0, 8'd0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] byte_value = 8'h00;
    logic       event_valid;
    logic       event_stall = 1'b0;
    logic [2:0] event_kind;
    logic [8:0] channel;
    logic [7:0] value;

    // Decoder model state
    msd_pkg::phase_t ph_q = msd_pkg::PH_COUNT;
    logic [7:0] song_notes = 8'd0;
    logic [7:0] load_pos = 8'd0;
    logic [4:0] inst_chan = 5'd0;
    logic [7:0] chan_tbl [msd_pkg::TABLE_DEPTH];
    logic [7:0] val_tbl [msd_pkg::TABLE_DEPTH];

    evt_t       pending_evts [$];
    row_chk_t   cur_chk = CHK_MODEL;
    evt_t       cur_ev = NO_EVT;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         err_cnt = 0;
    int         bytes_sent = 0;
    int         bytes_taken = 0;
    int         events_seen = 0;
    int         song_cnt = 0;
    int         cycle_cnt = 0;
    int         kind_cnt [6];
    bit         big_done = 1'b0;

    music_sequence_command_decoder_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_value  (byte_value),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .channel     (channel),
        .value       (value)
    );

    always #5 clk = ~clk;

    // Decode one accepted byte; returns 1 when it yields an event
    function automatic bit decode_byte(input logic [7:0] b, output evt_t ev);
        int n;
        int bi;
        n  = song_notes;
        bi = b;
        ev = NO_EVT;
        case (ph_q)
            msd_pkg::PH_CHANS:
            begin
                chan_tbl[load_pos] = b;
                if (int'(load_pos) + 1 >= n)
                begin
                    load_pos = 8'd0;
                    ph_q     = msd_pkg::PH_VALUES;
                end
                else
                    load_pos = load_pos + 8'd1;
                return 1'b0;
            end
            msd_pkg::PH_VALUES:
            begin
                val_tbl[load_pos] = b;
                if (int'(load_pos) + 1 >= n)
                begin
                    load_pos = 8'd0;
                    ph_q     = msd_pkg::PH_CMD;
                end
                else
                    load_pos = load_pos + 8'd1;
                return 1'b0;
            end
            msd_pkg::PH_INST:
            begin
                ev.kind = msd_pkg::EV_INST;
                ev.chan = 9'(inst_chan);
                ev.val  = b;
                ph_q    = msd_pkg::PH_CMD;
                return 1'b1;
            end
            msd_pkg::PH_CMD:
            begin
                // priority order; sums are taken without wrap
                if (bi < n)
                begin
                    ev.kind = msd_pkg::EV_NOTE;
                    ev.chan = 9'(chan_tbl[b]) + 9'd1;
                    ev.val  = val_tbl[b];
                end
                else if (bi < n + int'(msd_pkg::REST_SPAN))
                begin
                    ev.kind = msd_pkg::EV_REST;
                    ev.chan = 9'(bi - n + 1);
                end
                else if (bi < n + int'(msd_pkg::INST_SPAN))
                begin
                    inst_chan = 5'(bi - n - int'(msd_pkg::INST_OFFSET));
                    ph_q      = msd_pkg::PH_INST;
                    return 1'b0;
                end
                else if (b < msd_pkg::CODE_END_LOOP)
                begin
                    ev.kind = msd_pkg::EV_ROW;
                    ev.val  = 8'(bi - n - int'(msd_pkg::INST_SPAN));
                end
                else
                begin
                    ev.kind = (b == msd_pkg::CODE_END_LOOP) ? msd_pkg::EV_END_LOOP
                                                            : msd_pkg::EV_END_STOP;
                    ph_q    = msd_pkg::PH_COUNT;
                end
                return 1'b1;
            end
            default:
            begin
                song_notes = b;
                load_pos   = 8'd0;
                ph_q       = (b == 8'd0) ? msd_pkg::PH_CMD : msd_pkg::PH_CHANS;
                return 1'b0;
            end
        endcase
    endfunction

    // Next random word: well-formed song content, some noise in commands
    function automatic logic [7:0] pick_byte(input bit wrap_up);
        int n;
        int r;
        n = song_notes;
        r = $urandom_range(0, 99);
        case (ph_q)
            msd_pkg::PH_COUNT:
            begin
                // one song with a big table early on, the rest small
                if (!big_done && song_cnt >= 2)
                begin
                    big_done = 1'b1;
                    return 8'($urandom_range(8'hD0, 8'hDF));
                end
                if (r < 75)
                    return 8'($urandom_range(0, 6));
                return 8'($urandom_range(7, 48));
            end
            msd_pkg::PH_CMD:
            begin
                if (wrap_up || r < 4)
                    return $urandom_range(0, 1) ? msd_pkg::CODE_END_LOOP
                                                : msd_pkg::CODE_END_STOP;
                if (r < 10)
                    return 8'($urandom_range(0, 255));
                if (r < 45 && n > 0)
                    return 8'($urandom_range(0, n - 1));
                if (r < 60)
                    return 8'(n + $urandom_range(0, 15));
                if (r < 75)
                    return 8'(n + int'(msd_pkg::REST_SPAN) + $urandom_range(0, 15));
                if (n + int'(msd_pkg::INST_SPAN) <= 253)
                    return 8'($urandom_range(n + int'(msd_pkg::INST_SPAN), 253));
                return 8'($urandom_range(0, 255));
            end
            default:
                return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one word, with random gaps ahead of it, and hold until taken
    task automatic send_byte(input logic [7:0] b, input row_chk_t chk,
                             input evt_t ev);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            byte_value <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        cur_chk = chk;
        cur_ev  = ev;
        byte_valid <= 1'b1;
        byte_value <= b;
        do
            @(posedge clk);
        while (byte_stall !== 1'b0);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic field_check(input string what, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, what, want, got);
        end
    endtask

    // Receiver stalls at random
    always @(negedge clk)
        event_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_cnt, pending_evts.size());
            $display("music_sequence_command_decoder_core verification failed");
            $finish;
        end
    end

    // Event check, then model update for the word taken at this edge
    always @(posedge clk)
    begin : monitor
        evt_t want;
        evt_t pred;
        bit   fires;
        if (rst_n)
        begin
            if (event_valid && !event_stall)
            begin
                events_seen++;
                if (event_kind <= msd_pkg::EV_END_STOP)
                    kind_cnt[event_kind]++;
                if (pending_evts.size() == 0)
                begin
                    err_cnt++;
                    $display({"%0t ns: unexpected event, expected none, ",
                              "got kind %0d channel %0d value %0d"},
                             $time, event_kind, channel, value);
                end
                else
                begin
                    want = pending_evts.pop_front();
                    field_check("event_kind", 9'(want.kind), 9'(event_kind));
                    field_check("channel", want.chan, channel);
                    field_check("value", 9'(want.val), 9'(value));
                end
            end
            if (byte_valid && !byte_stall)
            begin
                bytes_taken++;
                if (ph_q == msd_pkg::PH_COUNT)
                    song_cnt++;
                fires = decode_byte(byte_value, pred);
                case (cur_chk)
                    CHK_EVENT: pending_evts.push_back(cur_ev);
                    CHK_QUIET: ;
                    default:
                        if (fires)
                            pending_evts.push_back(pred);
                endcase
            end
        end
    end

    initial
    begin
        int final_notes;
        int budget;
        int base;
        foreach (kind_cnt[k])
            kind_cnt[k] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        send_idle_pct = 36;
        recv_idle_pct = 75;
        foreach (DIR_ROWS[i])
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].chk, DIR_ROWS[i].ev);

        // random songs in three idle patterns; the last ends with a big song
        final_notes = $urandom_range(8'hE0, 8'hFF);
        base   = bytes_sent;
        budget = ITEM_TARGET - base - 2 * final_notes - FINAL_CMDS;
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 36 : (p == 1) ? 75 : 0;
            recv_idle_pct = (p == 0) ? 75 : (p == 1) ? 36 : 0;
            while (bytes_sent - base < budget * (p + 1) / 3)
                send_byte(pick_byte(1'b0), CHK_MODEL, NO_EVT);
            if (p == 2)
            begin
                while (ph_q != msd_pkg::PH_COUNT)
                    send_byte(pick_byte(1'b1), CHK_MODEL, NO_EVT);
                // note count this large never reaches an end code again
                send_byte(8'(final_notes), CHK_MODEL, NO_EVT);
                repeat (2 * final_notes + FINAL_CMDS)
                    send_byte(8'($urandom_range(0, 255)), CHK_MODEL, NO_EVT);
            end
            byte_valid <= 1'b0;
            // hold off until every expected event is out
            while (pending_evts.size() != 0)
                @(negedge clk);
        end

        repeat (SETTLE_TICKS) @(negedge clk);
        $display("covered %0d words over %0d songs, %0d events checked",
                 bytes_taken, song_cnt, events_seen);
        $display({"by kind: note %0d, rest %0d, instrument %0d, row %0d, ",
                  "end loop %0d, end stop %0d"},
                 kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3],
                 kind_cnt[4], kind_cnt[5]);
        if (err_cnt == 0)
            $display("music_sequence_command_decoder_core verification clean");
        else
            $display("music_sequence_command_decoder_core verification failed");
        $finish;
    end

endmodule
